### rtl/enem_pkg.sv
`default_nettype none
// ----------------------------------------------------------------------------
// enem_pkg
// Shared types, widths and fixed-point constants of the edge normal envelope
// mask unit.
// ----------------------------------------------------------------------------
package enem_pkg;

  localparam int CORDIC_STEPS = 24;
  localparam int CW           = 36;  // setup CORDIC word
  localparam int BW           = 34;  // per-pixel CORDIC word
  localparam int TAN_W        = 19;  // tangent code, enough for 16 fraction bits
  localparam int RHO_W        = 24;
  localparam int TH_W         = 42;  // unreduced Q30 pixel angle
  localparam int RED_STAGES   = 4;   // up to fifteen whole turns removed
  localparam int QUEUE_DEPTH  = 4;
  localparam int RHO_FRAC     = 8;

  localparam longint Q30_PI       = 64'sd3373259426;
  localparam longint Q30_HALF_PI  = 64'sd1686629713;
  localparam longint Q30_TWO_PI   = 64'sd6746518852;
  localparam longint Q30_INV_GAIN = 64'sd652032874;

  localparam logic signed [TH_W-1:0] PI_TH       = TH_W'(Q30_PI);
  localparam logic signed [TH_W-1:0] HALF_PI_TH  = TH_W'(Q30_HALF_PI);
  localparam logic signed [TH_W-1:0] TWO_PI_TH   = TH_W'(Q30_TWO_PI);
  localparam logic signed [TH_W-1:0] INV_GAIN_TH = TH_W'(Q30_INV_GAIN);

  // Register indexes on the configuration port.
  localparam logic [2:0] REG_FIRST_ROW       = 3'd0;
  localparam logic [2:0] REG_FIRST_COL       = 3'd1;
  localparam logic [2:0] REG_END_ROW         = 3'd2;
  localparam logic [2:0] REG_END_COL         = 3'd3;
  localparam logic [2:0] REG_WINDOW_LAST_ROW = 3'd4;
  localparam logic [2:0] REG_WINDOW_LAST_COL = 3'd5;

  typedef struct packed {
    logic [9:0] first_row;
    logic [9:0] first_col;
    logic [9:0] end_row;
    logic [9:0] end_col;
    logic [9:0] window_last_row;
    logic [9:0] window_last_col;
  } cfg_t;

  typedef struct packed {
    logic signed [TAN_W-1:0] tangent;
    logic signed [RHO_W-1:0] near_rho;
    logic signed [RHO_W-1:0] far_rho;
    logic signed [10:0]      top_x;
    logic signed [10:0]      top_y;
    logic signed [10:0]      bottom_x;
    logic signed [10:0]      bottom_y;
  } setup_t;

  typedef struct packed {
    logic [15:0] mag;
    logic        first;
    logic        done;
    logic [9:0]  row;
    logic [9:0]  col;
    logic [9:0]  last_row;
    logic [9:0]  last_col;
  } tag_t;

  typedef struct packed {
    tag_t                   tag;
    logic signed [TH_W-1:0] th;
  } item_t;

  // Arctangent of 2^-i in Q30.
  function automatic logic [29:0] atan_q30(int i);
    logic [29:0] a;
    unique case (i)
      0:  a = 30'd843314857;
      1:  a = 30'd497837830;
      2:  a = 30'd263043837;
      3:  a = 30'd133525159;
      4:  a = 30'd67021687;
      5:  a = 30'd33543516;
      6:  a = 30'd16775851;
      7:  a = 30'd8388437;
      8:  a = 30'd4194283;
      9:  a = 30'd2097149;
      10: a = 30'd1048576;
      11: a = 30'd524288;
      12: a = 30'd262144;
      13: a = 30'd131072;
      14: a = 30'd65536;
      15: a = 30'd32768;
      16: a = 30'd16384;
      17: a = 30'd8192;
      18: a = 30'd4096;
      19: a = 30'd2048;
      20: a = 30'd1024;
      21: a = 30'd512;
      22: a = 30'd256;
      23: a = 30'd128;
      default: a = 30'd0;
    endcase
    return a;
  endfunction

  // Threshold and step of the range reduction stage that removes 2^j turns.
  function automatic logic signed [TH_W-1:0] red_limit(int j);
    return TH_W'(Q30_PI + ((64'sd1 <<< j) - 64'sd1) * Q30_TWO_PI);
  endfunction

  function automatic logic signed [TH_W-1:0] red_step(int j);
    return TH_W'((64'sd1 <<< j) * Q30_TWO_PI);
  endfunction

endpackage
`default_nettype wire

### rtl/enem_setup.sv
`default_nettype none
// ----------------------------------------------------------------------------
// enem_setup
// Orders the endpoints and works out the tangent angle and both endpoint
// projections with one shared iterative CORDIC and one multiplier.
// ----------------------------------------------------------------------------
module enem_setup #(
  parameter int ANGLE_FRAC_BITS = 12
) (
  input  wire logic            clk,
  input  wire logic            rst,
  input  wire logic            start,
  input  wire enem_pkg::cfg_t  cfg,
  output logic                 busy,
  output enem_pkg::setup_t     pend
);

  localparam int CW  = enem_pkg::CW;
  localparam int TSH = 30 - ANGLE_FRAC_BITS;
  localparam int PW  = 47;
  localparam logic signed [CW-1:0] T_RND   = CW'(64'sd1 <<< (29 - ANGLE_FRAC_BITS));
  localparam logic signed [PW-1:0] RHO_RND = PW'(64'sd1 <<< (29 - enem_pkg::RHO_FRAC));
  localparam logic signed [CW-1:0] PI_C    = CW'(enem_pkg::PI_TH);
  localparam logic signed [CW-1:0] HPI_C   = CW'(enem_pkg::HALF_PI_TH);
  localparam logic signed [CW-1:0] TPI_C   = CW'(enem_pkg::TWO_PI_TH);
  localparam logic signed [CW-1:0] GAIN_C  = CW'(enem_pkg::INV_GAIN_TH);

  typedef enum logic [6:0] {
    S_IDLE  = 7'b0000001,
    S_ORDER = 7'b0000010,
    S_VEC   = 7'b0000100,
    S_ROUND = 7'b0001000,
    S_FOLD  = 7'b0010000,
    S_ROT   = 7'b0100000,
    S_RHO   = 7'b1000000
  } state_t;

  state_t                 state;
  logic [4:0]             cnt;
  logic signed [CW-1:0]   cx, cy, cz;
  logic signed [CW-1:0]   cos_v, sin_v;
  logic                   neg;
  logic signed [PW-1:0]   acc;

  logic signed [10:0]     x1, y1, x2, y2, tx, ty, bx, by;
  logic                   swap;
  logic signed [11:0]     dx, dy;
  logic signed [CW-1:0]   ax, ay;
  logic signed [CW-1:0]   at, xs, ys;
  logic                   sigma;
  logic signed [CW-1:0]   tz, th, th2;
  logic signed [10:0]     a_sel;
  logic signed [CW-1:0]   b_sel;
  logic signed [PW-1:0]   prod, sum, rho_full;

  always_comb begin
    x1   = $signed({1'b0, cfg.first_col}) - 11'sd1;
    y1   = 11'sd1 - $signed({1'b0, cfg.first_row});
    x2   = $signed({1'b0, cfg.end_col}) - 11'sd1;
    y2   = 11'sd1 - $signed({1'b0, cfg.end_row});
    swap = (y1 != y2) ? (y1 < y2) : (x2 < x1);
    tx   = swap ? x2 : x1;
    ty   = swap ? y2 : y1;
    bx   = swap ? x1 : x2;
    by   = swap ? y1 : y2;
    dx   = 12'(bx) - 12'(tx);
    dy   = 12'(by) - 12'(ty);
    ax   = CW'(dx) <<< 20;
    ay   = CW'(dy) <<< 20;

    at    = CW'({1'b0, enem_pkg::atan_q30(int'(cnt))});
    xs    = cx >>> cnt;
    ys    = cy >>> cnt;
    sigma = (state == S_VEC) ? cy[CW-1] : !cz[CW-1];

    tz = cz + T_RND;
    th = cz;
    if (th > PI_C) begin
      th2 = th - TPI_C;
    end else if (th <= -PI_C) begin
      th2 = th + TPI_C;
    end else begin
      th2 = th;
    end

    a_sel    = cnt[0] ? (cnt[1] ? by : ty) : (cnt[1] ? bx : tx);
    b_sel    = cnt[0] ? sin_v : cos_v;
    prod     = PW'(a_sel) * PW'(b_sel);
    sum      = (cnt[0] ? acc : '0) + prod;
    rho_full = (sum + RHO_RND) >>> (30 - enem_pkg::RHO_FRAC);
  end

  assign busy = (state != S_IDLE);

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_ORDER;
    end else if (start) begin
      state <= S_ORDER;
    end else begin
      unique case (state)
        S_IDLE:  state <= S_IDLE;
        S_ORDER: state <= (dy == 12'sd0 || dx == 12'sd0) ? S_ROUND : S_VEC;
        S_VEC:   if (cnt == 5'(enem_pkg::CORDIC_STEPS - 1)) state <= S_ROUND;
        S_ROUND: state <= S_FOLD;
        S_FOLD:  state <= S_ROT;
        S_ROT:   if (cnt == 5'(enem_pkg::CORDIC_STEPS - 1)) state <= S_RHO;
        S_RHO:   if (cnt == 5'd3) state <= S_IDLE;
        default: state <= S_IDLE;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    unique case (state)
      S_ORDER: begin
        pend.top_x    <= tx;
        pend.top_y    <= ty;
        pend.bottom_x <= bx;
        pend.bottom_y <= by;
        cnt           <= 5'd0;
        // Axis-aligned and degenerate edges bypass the vectoring pass.
        if (dy == 12'sd0) begin
          cz <= dx[11] ? PI_C : '0;
        end else if (dx == 12'sd0) begin
          cz <= dy[11] ? -HPI_C : HPI_C;
        end else if (dx[11]) begin
          cx <= -ax;
          cy <= -ay;
          cz <= dy[11] ? -PI_C : PI_C;
        end else begin
          cx <= ax;
          cy <= ay;
          cz <= '0;
        end
      end
      S_VEC, S_ROT: begin
        cnt <= cnt + 5'd1;
        if (sigma) begin
          cx <= cx - ys;
          cy <= cy + xs;
          cz <= cz - at;
        end else begin
          cx <= cx + ys;
          cy <= cy - xs;
          cz <= cz + at;
        end
        if (state == S_ROT && cnt == 5'(enem_pkg::CORDIC_STEPS - 1)) begin
          cos_v <= neg ? -(cx - (sigma ? ys : -ys)) : (cx - (sigma ? ys : -ys));
          sin_v <= neg ? -(cy + (sigma ? xs : -xs)) : (cy + (sigma ? xs : -xs));
          cnt   <= 5'd0;
        end
      end
      S_ROUND: begin
        pend.tangent <= enem_pkg::TAN_W'(tz >>> TSH);
        cz           <= (tz >>> TSH) <<< TSH;
      end
      S_FOLD: begin
        cx  <= GAIN_C;
        cy  <= '0;
        cnt <= 5'd0;
        if (th2 > HPI_C) begin
          cz  <= th2 - PI_C;
          neg <= 1'b1;
        end else if (th2 < -HPI_C) begin
          cz  <= th2 + PI_C;
          neg <= 1'b1;
        end else begin
          cz  <= th2;
          neg <= 1'b0;
        end
      end
      S_RHO: begin
        cnt <= cnt + 5'd1;
        if (!cnt[0]) begin
          acc <= sum;
        end else if (cnt[1]) begin
          pend.far_rho <= enem_pkg::RHO_W'(rho_full);
        end else begin
          pend.near_rho <= enem_pkg::RHO_W'(rho_full);
        end
      end
      default: begin
        cnt <= cnt;
      end
    endcase
  end

endmodule
`default_nettype wire

### rtl/enem_front.sv
`default_nettype none
// ----------------------------------------------------------------------------
// enem_front
// Accepts pixels, tracks the raster position, marks the first and last pixel
// of each window and forms the unreduced angle difference.
// ----------------------------------------------------------------------------
module enem_front #(
  parameter int WINDOW_ROWS     = 1024,
  parameter int WINDOW_COLS     = 1024,
  parameter int ANGLE_FRAC_BITS = 12
) (
  input  wire logic                                clk,
  input  wire logic                                rst,
  input  wire logic                                in_valid,
  output logic                                     in_stall,
  input  wire logic [15:0]                         pixel_magnitude,
  input  wire logic signed [14:0]                  pixel_angle,
  input  wire logic [9:0]                          window_last_row,
  input  wire logic [9:0]                          window_last_col,
  input  wire logic signed [enem_pkg::TAN_W-1:0]   pend_tangent,
  input  wire logic                                setup_busy,
  input  wire logic                                q_full,
  output logic                                     push,
  output enem_pkg::item_t                          push_item
);

  localparam int TSH = 30 - ANGLE_FRAC_BITS;
  localparam int DW  = enem_pkg::TAN_W + 1;

  logic [9:0]                        row, col;
  logic signed [enem_pkg::TAN_W-1:0] act_tangent;
  logic [9:0]                        lr, lc;
  logic                              first;
  logic signed [enem_pkg::TAN_W-1:0] t_use;
  logic signed [DW-1:0]              diff;

  always_comb begin
    lr = ({3'b0, window_last_row} > 13'(WINDOW_ROWS - 1)) ? 10'(WINDOW_ROWS - 1)
                                                         : window_last_row;
    lc = ({3'b0, window_last_col} > 13'(WINDOW_COLS - 1)) ? 10'(WINDOW_COLS - 1)
                                                         : window_last_col;
    first = (row == 10'd0) && (col == 10'd0);
    t_use = first ? pend_tangent : act_tangent;
    diff  = DW'(t_use) - DW'(pixel_angle);

    push_item.tag.mag      = pixel_magnitude;
    push_item.tag.first    = first;
    push_item.tag.done     = (col >= lc) && (row >= lr);
    push_item.tag.row      = row;
    push_item.tag.col      = col;
    push_item.tag.last_row = lr;
    push_item.tag.last_col = lc;
    push_item.th           = enem_pkg::TH_W'(diff) <<< TSH;
  end

  assign in_stall = setup_busy || q_full;
  assign push     = in_valid && !in_stall;

  always_ff @(posedge clk) begin
    if (rst) begin
      row <= 10'd0;
      col <= 10'd0;
    end else if (push) begin
      if (col >= lc) begin
        col <= 10'd0;
        row <= (row >= lr) ? 10'd0 : row + 10'd1;
      end else begin
        col <= col + 10'd1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (push && first) begin
      act_tangent <= pend_tangent;
    end
  end

endmodule
`default_nettype wire

### rtl/enem_queue.sv
`default_nettype none
// ----------------------------------------------------------------------------
// enem_queue
// Short first-in first-out queue between the front and back parts.
// ----------------------------------------------------------------------------
module enem_queue (
  input  wire logic             clk,
  input  wire logic             rst,
  input  wire logic             push,
  input  wire enem_pkg::item_t  push_item,
  output logic                  full,
  input  wire logic             pop,
  output enem_pkg::item_t       pop_item,
  output logic                  valid
);

  localparam int D  = enem_pkg::QUEUE_DEPTH;
  localparam int AW = $clog2(D);

  enem_pkg::item_t mem [D];
  logic [AW-1:0]   wp, rp;
  logic [AW:0]     cnt;

  assign full     = (cnt == (AW + 1)'(D));
  assign valid    = (cnt != '0);
  assign pop_item = mem[rp];

  always_ff @(posedge clk) begin
    if (rst) begin
      wp  <= '0;
      rp  <= '0;
      cnt <= '0;
    end else begin
      if (push) wp <= wp + 1'b1;
      if (pop)  rp <= rp + 1'b1;
      cnt <= cnt + (AW + 1)'(push) - (AW + 1)'(pop);
    end
  end

  always_ff @(posedge clk) begin
    if (push) begin
      mem[wp] <= push_item;
    end
  end

endmodule
`default_nettype wire

### rtl/enem_back.sv
`default_nettype none
// ----------------------------------------------------------------------------
// enem_back
// Per-pixel pipeline: angle range reduction, a 24-stage rotation CORDIC, the
// magnitude multiply, the envelope test and the bounding box update.
// ----------------------------------------------------------------------------
module enem_back (
  input  wire logic                  clk,
  input  wire logic                  rst,
  input  wire logic                  q_valid,
  input  wire enem_pkg::item_t       q_item,
  output logic                       q_pop,
  input  wire enem_pkg::setup_t      pend,
  input  wire logic                  out_stall,
  output logic                       out_valid,
  output logic                       inside_res,
  output logic                       window_done,
  output logic [9:0]                 box_min_row,
  output logic [9:0]                 box_min_col,
  output logic [9:0]                 box_max_row,
  output logic [9:0]                 box_max_col,
  output logic signed [14:0]         tangent_angle,
  output logic signed [10:0]         top_x,
  output logic signed [10:0]         top_y,
  output logic signed [10:0]         bottom_x,
  output logic signed [10:0]         bottom_y
);

  localparam int NR    = enem_pkg::RED_STAGES;
  localparam int NC    = enem_pkg::CORDIC_STEPS;
  localparam int BW    = enem_pkg::BW;
  localparam int TH_W  = enem_pkg::TH_W;
  localparam int RHO_W = enem_pkg::RHO_W;
  localparam int MW    = BW + 17;
  localparam logic signed [MW-1:0] PROJ_RND = MW'(64'sd1 <<< (33 - enem_pkg::RHO_FRAC));

  logic en;

  // The whole pipeline advances together; the queue absorbs input while the
  // output is stalled.
  assign en    = !out_valid || !out_stall;
  assign q_pop = en && q_valid;

  // Range reduction.
  logic                   r_valid [NR];
  enem_pkg::tag_t         r_tag   [NR];
  logic signed [TH_W-1:0] r_th    [NR];

  for (genvar k = 0; k < NR; k++) begin : g_red
    localparam int J = NR - 1 - k;
    localparam logic signed [TH_W-1:0] LIM  = enem_pkg::red_limit(J);
    localparam logic signed [TH_W-1:0] STEP = enem_pkg::red_step(J);
    logic                   v_in;
    enem_pkg::tag_t         tag_in;
    logic signed [TH_W-1:0] th_in;
    if (k == 0) begin : g_src
      assign v_in   = q_pop;
      assign tag_in = q_item.tag;
      assign th_in  = q_item.th;
    end else begin : g_src
      assign v_in   = r_valid[k-1];
      assign tag_in = r_tag[k-1];
      assign th_in  = r_th[k-1];
    end
    always_ff @(posedge clk) begin
      if (rst) begin
        r_valid[k] <= 1'b0;
      end else if (en) begin
        r_valid[k] <= v_in;
      end
    end
    always_ff @(posedge clk) begin
      if (en) begin
        r_tag[k] <= tag_in;
        if (th_in > LIM) begin
          r_th[k] <= th_in - STEP;
        end else if (th_in <= -LIM) begin
          r_th[k] <= th_in + STEP;
        end else begin
          r_th[k] <= th_in;
        end
      end
    end
  end

  // Fold into the right half-plane.
  logic                 f_valid;
  enem_pkg::tag_t       f_tag;
  logic signed [BW-1:0] f_z;
  logic                 f_neg;

  always_ff @(posedge clk) begin
    if (rst) begin
      f_valid <= 1'b0;
    end else if (en) begin
      f_valid <= r_valid[NR-1];
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      f_tag <= r_tag[NR-1];
      if (r_th[NR-1] > enem_pkg::HALF_PI_TH) begin
        f_z   <= BW'(r_th[NR-1] - enem_pkg::PI_TH);
        f_neg <= 1'b1;
      end else if (r_th[NR-1] < -enem_pkg::HALF_PI_TH) begin
        f_z   <= BW'(r_th[NR-1] + enem_pkg::PI_TH);
        f_neg <= 1'b1;
      end else begin
        f_z   <= BW'(r_th[NR-1]);
        f_neg <= 1'b0;
      end
    end
  end

  // Rotation CORDIC, one stage per step.
  logic                 c_valid [NC];
  enem_pkg::tag_t       c_tag   [NC];
  logic                 c_neg   [NC];
  logic signed [BW-1:0] c_x     [NC];
  logic signed [BW-1:0] c_y     [NC];
  logic signed [BW-1:0] c_z     [NC];

  for (genvar i = 0; i < NC; i++) begin : g_cordic
    localparam logic signed [BW-1:0] AT = BW'({1'b0, enem_pkg::atan_q30(i)});
    logic                 v_in, neg_in;
    enem_pkg::tag_t       tag_in;
    logic signed [BW-1:0] x_in, y_in, z_in;
    if (i == 0) begin : g_src
      assign v_in   = f_valid;
      assign tag_in = f_tag;
      assign neg_in = f_neg;
      assign x_in   = BW'(enem_pkg::INV_GAIN_TH);
      assign y_in   = '0;
      assign z_in   = f_z;
    end else begin : g_src
      assign v_in   = c_valid[i-1];
      assign tag_in = c_tag[i-1];
      assign neg_in = c_neg[i-1];
      assign x_in   = c_x[i-1];
      assign y_in   = c_y[i-1];
      assign z_in   = c_z[i-1];
    end
    always_ff @(posedge clk) begin
      if (rst) begin
        c_valid[i] <= 1'b0;
      end else if (en) begin
        c_valid[i] <= v_in;
      end
    end
    always_ff @(posedge clk) begin
      if (en) begin
        c_tag[i] <= tag_in;
        c_neg[i] <= neg_in;
        if (!z_in[BW-1]) begin
          c_x[i] <= x_in - (y_in >>> i);
          c_y[i] <= y_in + (x_in >>> i);
          c_z[i] <= z_in - AT;
        end else begin
          c_x[i] <= x_in + (y_in >>> i);
          c_y[i] <= y_in - (x_in >>> i);
          c_z[i] <= z_in + AT;
        end
      end
    end
  end

  // Sign fix, multiply, envelope test.
  logic                    n_valid, m_valid, p_valid;
  enem_pkg::tag_t          n_tag, m_tag, p_tag;
  logic signed [BW-1:0]    n_c;
  logic signed [MW-1:0]    m_prod;
  logic                    p_inside;
  logic signed [RHO_W-1:0] act_near, act_far, near_sel, far_sel, proj;

  always_comb begin
    near_sel = m_tag.first ? pend.near_rho : act_near;
    far_sel  = m_tag.first ? pend.far_rho : act_far;
    proj     = RHO_W'((m_prod + PROJ_RND) >>> (34 - enem_pkg::RHO_FRAC));
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      n_valid <= 1'b0;
      m_valid <= 1'b0;
      p_valid <= 1'b0;
    end else if (en) begin
      n_valid <= c_valid[NC-1];
      m_valid <= n_valid;
      p_valid <= m_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      n_tag    <= c_tag[NC-1];
      n_c      <= c_neg[NC-1] ? -c_x[NC-1] : c_x[NC-1];
      m_tag    <= n_tag;
      m_prod   <= MW'($signed({1'b0, n_tag.mag})) * MW'(n_c);
      p_tag    <= m_tag;
      p_inside <= (proj >= near_sel) && (proj <= far_sel);
      if (m_valid && m_tag.first) begin
        act_near <= pend.near_rho;
        act_far  <= pend.far_rho;
      end
    end
  end

  // Bounding box and output register.
  logic [9:0] b_minr, b_minc, b_maxr, b_maxc;

  always_comb begin
    b_minr = p_tag.first ? p_tag.last_row : box_min_row;
    b_minc = p_tag.first ? p_tag.last_col : box_min_col;
    b_maxr = p_tag.first ? 10'd0 : box_max_row;
    b_maxc = p_tag.first ? 10'd0 : box_max_col;
    if (p_inside) begin
      if (p_tag.row < b_minr) b_minr = p_tag.row;
      if (p_tag.col < b_minc) b_minc = p_tag.col;
      if (p_tag.row > b_maxr) b_maxr = p_tag.row;
      if (p_tag.col > b_maxc) b_maxc = p_tag.col;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (en) begin
      out_valid <= p_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (en && p_valid) begin
      inside_res  <= p_inside;
      window_done <= p_tag.done;
      box_min_row <= b_minr;
      box_min_col <= b_minc;
      box_max_row <= b_maxr;
      box_max_col <= b_maxc;
      if (p_tag.first) begin
        tangent_angle <= pend.tangent[14:0];
        top_x         <= pend.top_x;
        top_y         <= pend.top_y;
        bottom_x      <= pend.bottom_x;
        bottom_y      <= pend.bottom_y;
      end
    end
  end

endmodule
`default_nettype wire

### rtl/edge_normal_envelope_mask_unit.sv
`default_nettype none
// ----------------------------------------------------------------------------
// edge_normal_envelope_mask_unit
// One pixel per cycle is sustained while no endpoint setup runs and the
// output is not stalled, set by the fully pipelined per-pixel CORDIC.
// After reset and every register write the endpoint setup runs on a shared
// iterative CORDIC, skipping vectoring for horizontal, vertical or degenerate
// edges; pixels are held off meanwhile. Reset is synchronous.
// ----------------------------------------------------------------------------
module edge_normal_envelope_mask_unit #(
  parameter int WINDOW_ROWS     = 1024,
  parameter int WINDOW_COLS     = 1024,
  parameter int ANGLE_FRAC_BITS = 12
) (
  input  wire logic               clk,
  input  wire logic               rst,
  input  wire logic               psel,
  input  wire logic               penable,
  input  wire logic               pwrite,
  input  wire logic [4:0]         paddr,
  input  wire logic [31:0]        pwdata,
  output logic [31:0]             prdata,
  output logic                    pready,
  input  wire logic               in_valid,
  output logic                    in_stall,
  input  wire logic [15:0]        pixel_magnitude,
  input  wire logic signed [14:0] pixel_angle,
  output logic                    out_valid,
  input  wire logic               out_stall,
  output logic                    inside_res,
  output logic                    window_done,
  output logic [9:0]              box_min_row,
  output logic [9:0]              box_min_col,
  output logic [9:0]              box_max_row,
  output logic [9:0]              box_max_col,
  output logic signed [14:0]      tangent_angle,
  output logic signed [10:0]      top_x,
  output logic signed [10:0]      top_y,
  output logic signed [10:0]      bottom_x,
  output logic signed [10:0]      bottom_y
);

  enem_pkg::cfg_t   cfg;
  enem_pkg::setup_t pend;
  enem_pkg::item_t  push_item, pop_item;
  logic             wr, setup_busy, push, q_full, q_pop, q_valid;
  logic [2:0]       idx;

  assign pready = 1'b1;
  assign idx    = paddr[4:2];
  assign wr     = psel && penable && pwrite && pready;

  always_ff @(posedge clk) begin
    if (rst) begin
      cfg.first_row       <= 10'd1;
      cfg.first_col       <= 10'd1;
      cfg.end_row         <= 10'd1;
      cfg.end_col         <= 10'd1;
      cfg.window_last_row <= 10'd0;
      cfg.window_last_col <= 10'd0;
    end else if (wr) begin
      unique case (idx)
        enem_pkg::REG_FIRST_ROW:       cfg.first_row       <= pwdata[9:0];
        enem_pkg::REG_FIRST_COL:       cfg.first_col       <= pwdata[9:0];
        enem_pkg::REG_END_ROW:         cfg.end_row         <= pwdata[9:0];
        enem_pkg::REG_END_COL:         cfg.end_col         <= pwdata[9:0];
        enem_pkg::REG_WINDOW_LAST_ROW: cfg.window_last_row <= pwdata[9:0];
        enem_pkg::REG_WINDOW_LAST_COL: cfg.window_last_col <= pwdata[9:0];
        default:                       cfg                 <= cfg;
      endcase
    end
  end

  always_comb begin
    unique case (idx)
      enem_pkg::REG_FIRST_ROW:       prdata = {22'd0, cfg.first_row};
      enem_pkg::REG_FIRST_COL:       prdata = {22'd0, cfg.first_col};
      enem_pkg::REG_END_ROW:         prdata = {22'd0, cfg.end_row};
      enem_pkg::REG_END_COL:         prdata = {22'd0, cfg.end_col};
      enem_pkg::REG_WINDOW_LAST_ROW: prdata = {22'd0, cfg.window_last_row};
      enem_pkg::REG_WINDOW_LAST_COL: prdata = {22'd0, cfg.window_last_col};
      default:                       prdata = 32'd0;
    endcase
  end

  enem_setup #(
    .ANGLE_FRAC_BITS(ANGLE_FRAC_BITS)
  ) u_setup (
    .clk   (clk),
    .rst   (rst),
    .start (wr),
    .cfg   (cfg),
    .busy  (setup_busy),
    .pend  (pend)
  );

  enem_front #(
    .WINDOW_ROWS    (WINDOW_ROWS),
    .WINDOW_COLS    (WINDOW_COLS),
    .ANGLE_FRAC_BITS(ANGLE_FRAC_BITS)
  ) u_front (
    .clk             (clk),
    .rst             (rst),
    .in_valid        (in_valid),
    .in_stall        (in_stall),
    .pixel_magnitude (pixel_magnitude),
    .pixel_angle     (pixel_angle),
    .window_last_row (cfg.window_last_row),
    .window_last_col (cfg.window_last_col),
    .pend_tangent    (pend.tangent),
    .setup_busy      (setup_busy),
    .q_full          (q_full),
    .push            (push),
    .push_item       (push_item)
  );

  enem_queue u_queue (
    .clk       (clk),
    .rst       (rst),
    .push      (push),
    .push_item (push_item),
    .full      (q_full),
    .pop       (q_pop),
    .pop_item  (pop_item),
    .valid     (q_valid)
  );

  enem_back u_back (
    .clk           (clk),
    .rst           (rst),
    .q_valid       (q_valid),
    .q_item        (pop_item),
    .q_pop         (q_pop),
    .pend          (pend),
    .out_stall     (out_stall),
    .out_valid     (out_valid),
    .inside_res    (inside_res),
    .window_done   (window_done),
    .box_min_row   (box_min_row),
    .box_min_col   (box_min_col),
    .box_max_row   (box_max_row),
    .box_max_col   (box_max_col),
    .tangent_angle (tangent_angle),
    .top_x         (top_x),
    .top_y         (top_y),
    .bottom_x      (bottom_x),
    .bottom_y      (bottom_y)
  );

endmodule
`default_nettype wire

### rtl/enem_checker.sv
`default_nettype none
// ----------------------------------------------------------------------------
// enem_checker
// Port-level checks on the edge normal envelope mask unit.
// ----------------------------------------------------------------------------
module enem_checker (
  input wire logic       clk,
  input wire logic       rst,
  input wire logic       in_stall,
  input wire logic       out_valid,
  input wire logic       out_stall,
  input wire logic       inside_res,
  input wire logic       window_done,
  input wire logic [9:0] box_min_row,
  input wire logic [9:0] box_min_col,
  input wire logic [9:0] box_max_row,
  input wire logic [9:0] box_max_col
);

  // A stalled result is held until its transfer.
  a_hold: assert property (@(posedge clk) disable iff (rst)
    out_valid && out_stall |=> out_valid && $stable(inside_res) &&
      $stable(window_done) && $stable(box_min_row) && $stable(box_max_col))
    else $error("stalled result changed");

  // An inside pixel lies within the box, so the box cannot be inverted.
  a_box: assert property (@(posedge clk) disable iff (rst)
    out_valid && inside_res |-> box_min_row <= box_max_row &&
      box_min_col <= box_max_col)
    else $error("inside pixel with inverted box");

  // The endpoint setup runs straight after reset, so pixels are held off.
  a_setup: assert property (@(posedge clk) rst |=> in_stall)
    else $error("input taken before endpoint setup");

  a_rst: assert property (@(posedge clk) rst |=> !out_valid)
    else $error("result shown after reset");

endmodule

bind edge_normal_envelope_mask_unit enem_checker u_checker (
  .clk         (clk),
  .rst         (rst),
  .in_stall    (in_stall),
  .out_valid   (out_valid),
  .out_stall   (out_stall),
  .inside_res  (inside_res),
  .window_done (window_done),
  .box_min_row (box_min_row),
  .box_min_col (box_min_col),
  .box_max_row (box_max_row),
  .box_max_col (box_max_col)
);
`default_nettype wire

### tb/enem_checker.sv
// ----------------------------------------------------------------------------
// enem_tb_checker
// Watches the register port and both pixel channels of the envelope mask unit.
// It keeps its own copy of the registers and window state, works out the
// result of every accepted pixel, and compares each result transfer with the
// oldest prediction, field by field.
// ----------------------------------------------------------------------------
module enem_tb_checker (
  input  wire logic               clk,
  input  wire logic               rst,
  input  wire logic               psel,
  input  wire logic               penable,
  input  wire logic               pwrite,
  input  wire logic [4:0]         paddr,
  input  wire logic [31:0]        pwdata,
  input  wire logic               pready,
  input  wire logic               in_valid,
  input  wire logic               in_stall,
  input  wire logic [15:0]        pixel_magnitude,
  input  wire logic signed [14:0] pixel_angle,
  input  wire logic               out_valid,
  input  wire logic               out_stall,
  input  wire logic               inside_res,
  input  wire logic               window_done,
  input  wire logic [9:0]         box_min_row,
  input  wire logic [9:0]         box_min_col,
  input  wire logic [9:0]         box_max_row,
  input  wire logic [9:0]         box_max_col,
  input  wire logic signed [14:0] tangent_angle,
  input  wire logic signed [10:0] top_x,
  input  wire logic signed [10:0] top_y,
  input  wire logic signed [10:0] bottom_x,
  input  wire logic signed [10:0] bottom_y,
  output int                      errors,
  output int                      pending
);

  typedef struct packed {
    logic        is_in;
    logic        done;
    logic [9:0]  min_row;
    logic [9:0]  min_col;
    logic [9:0]  max_row;
    logic [9:0]  max_col;
    logic [14:0] tangent;
    logic [10:0] tx;
    logic [10:0] ty;
    logic [10:0] bx;
    logic [10:0] by;
  } mask_result_t;

  mask_result_t expected_results[$];

  logic [9:0] cfg_first_row, cfg_first_col, cfg_end_row, cfg_end_col;
  logic [9:0] cfg_last_row, cfg_last_col;
  logic [9:0] row_cnt, col_cnt;
  logic [9:0] min_row, min_col, max_row, max_col;
  longint     tan_code, near_proj, far_proj;
  longint     edge_tx, edge_ty, edge_bx, edge_by;

  function automatic longint arctan_step(int i);
    case (i)
      0:  return 843314857;
      1:  return 497837830;
      2:  return 263043837;
      3:  return 133525159;
      4:  return 67021687;
      5:  return 33543516;
      6:  return 16775851;
      7:  return 8388437;
      8:  return 4194283;
      9:  return 2097149;
      default: return longint'(1) << (30 - i);
    endcase
  endfunction

  function automatic void rot_sincos(input longint th, output longint c, output longint s);
    longint x, y, z, dx, dy;
    bit     neg;
    neg = 0;
    x = enem_pkg::Q30_INV_GAIN;
    y = 0;
    while (th > enem_pkg::Q30_PI) th -= enem_pkg::Q30_TWO_PI;
    while (th <= -enem_pkg::Q30_PI) th += enem_pkg::Q30_TWO_PI;
    if (th > enem_pkg::Q30_HALF_PI) begin
      th -= enem_pkg::Q30_PI;
      neg = 1;
    end else if (th < -enem_pkg::Q30_HALF_PI) begin
      th += enem_pkg::Q30_PI;
      neg = 1;
    end
    z = th;
    for (int i = 0; i < enem_pkg::CORDIC_STEPS; i++) begin
      dx = y >>> i;
      dy = x >>> i;
      if (z >= 0) begin
        x -= dx; y += dy; z -= arctan_step(i);
      end else begin
        x += dx; y -= dy; z += arctan_step(i);
      end
    end
    c = neg ? -x : x;
    s = neg ? -y : y;
  endfunction

  function automatic longint vec_atan2(longint dy, longint dx);
    longint x, y, z, xo;
    z = 0;
    if (dy == 0) return (dx < 0) ? enem_pkg::Q30_PI : 0;
    if (dx == 0) return (dy > 0) ? enem_pkg::Q30_HALF_PI : -enem_pkg::Q30_HALF_PI;
    x = dx <<< 20;
    y = dy <<< 20;
    if (dx < 0) begin
      x = -x; y = -y;
      z = (dy > 0) ? enem_pkg::Q30_PI : -enem_pkg::Q30_PI;
    end
    for (int i = 0; i < enem_pkg::CORDIC_STEPS; i++) begin
      xo = x;
      if (y >= 0) begin
        x += y >>> i; y -= xo >>> i; z += arctan_step(i);
      end else begin
        x -= y >>> i; y += xo >>> i; z -= arctan_step(i);
      end
    end
    return z;
  endfunction

  // Latches the ordered endpoints, tangent and projections, and inverts the box.
  task automatic open_window();
    longint x1, y1, x2, y2, tmp, c, s;
    x1 = longint'(cfg_first_col) - 1;
    y1 = 1 - longint'(cfg_first_row);
    x2 = longint'(cfg_end_col) - 1;
    y2 = 1 - longint'(cfg_end_row);
    if ((y1 != y2) ? (y1 < y2) : (x2 < x1)) begin
      tmp = x1; x1 = x2; x2 = tmp;
      tmp = y1; y1 = y2; y2 = tmp;
    end
    edge_tx = x1; edge_ty = y1; edge_bx = x2; edge_by = y2;
    tan_code = (vec_atan2(y2 - y1, x2 - x1) + (longint'(1) << 17)) >>> 18;
    rot_sincos(tan_code <<< 18, c, s);
    near_proj = (x1 * c + y1 * s + (longint'(1) << 21)) >>> 22;
    far_proj  = (x2 * c + y2 * s + (longint'(1) << 21)) >>> 22;
    min_row = cfg_last_row;
    min_col = cfg_last_col;
    max_row = 0;
    max_col = 0;
  endtask

  task automatic predict_pixel(logic [15:0] mag, logic signed [14:0] ang);
    longint       c, s, proj;
    mask_result_t r;
    if (row_cnt == 0 && col_cnt == 0) open_window();
    rot_sincos((tan_code - longint'(ang)) <<< 18, c, s);
    proj = (longint'(mag) * c + (longint'(1) << 25)) >>> 26;
    r.is_in = (proj >= near_proj) && (proj <= far_proj);
    if (r.is_in) begin
      if (row_cnt < min_row) min_row = row_cnt;
      if (col_cnt < min_col) min_col = col_cnt;
      if (row_cnt > max_row) max_row = row_cnt;
      if (col_cnt > max_col) max_col = col_cnt;
    end
    r.done    = (col_cnt >= cfg_last_col) && (row_cnt >= cfg_last_row);
    r.min_row = min_row;
    r.min_col = min_col;
    r.max_row = max_row;
    r.max_col = max_col;
    r.tangent = tan_code[14:0];
    r.tx      = edge_tx[10:0];
    r.ty      = edge_ty[10:0];
    r.bx      = edge_bx[10:0];
    r.by      = edge_by[10:0];
    expected_results.push_back(r);
    // A counter at or past the last index ends its row or window at once.
    if (col_cnt >= cfg_last_col) begin
      col_cnt = 0;
      if (row_cnt >= cfg_last_row) row_cnt = 0;
      else row_cnt++;
    end else begin
      col_cnt++;
    end
  endtask

  task automatic check_field(string name, longint exp_v, longint act_v);
    if (exp_v != act_v) begin
      errors++;
      $display("%0t: %s mismatch, expected %0h, got %0h", $time, name, exp_v, act_v);
    end
  endtask

  always @(posedge clk) begin
    mask_result_t e;
    if (rst) begin
      cfg_first_row = 1; cfg_first_col = 1; cfg_end_row = 1; cfg_end_col = 1;
      cfg_last_row = 0; cfg_last_col = 0;
      row_cnt = 0; col_cnt = 0;
      open_window();
      expected_results.delete();
      errors = 0;
    end else begin
      if (psel && penable && pwrite && pready) begin
        case (paddr[4:2])
          enem_pkg::REG_FIRST_ROW:       cfg_first_row = pwdata[9:0];
          enem_pkg::REG_FIRST_COL:       cfg_first_col = pwdata[9:0];
          enem_pkg::REG_END_ROW:         cfg_end_row   = pwdata[9:0];
          enem_pkg::REG_END_COL:         cfg_end_col   = pwdata[9:0];
          enem_pkg::REG_WINDOW_LAST_ROW: cfg_last_row  = pwdata[9:0];
          enem_pkg::REG_WINDOW_LAST_COL: cfg_last_col  = pwdata[9:0];
          default: ;
        endcase
      end
      if (in_valid && !in_stall) predict_pixel(pixel_magnitude, pixel_angle);
      if (out_valid && !out_stall) begin
        if (expected_results.size() == 0) begin
          errors++;
          $display("%0t: result transfer with no prediction waiting", $time);
        end else begin
          e = expected_results.pop_front();
          check_field("inside_res", e.is_in, inside_res);
          check_field("window_done", e.done, window_done);
          check_field("box_min_row", e.min_row, box_min_row);
          check_field("box_min_col", e.min_col, box_min_col);
          check_field("box_max_row", e.max_row, box_max_row);
          check_field("box_max_col", e.max_col, box_max_col);
          check_field("tangent_angle", e.tangent, tangent_angle[14:0]);
          check_field("top_x", e.tx, top_x[10:0]);
          check_field("top_y", e.ty, top_y[10:0]);
          check_field("bottom_x", e.bx, bottom_x[10:0]);
          check_field("bottom_y", e.by, bottom_y[10:0]);
        end
      end
    end
    pending = expected_results.size();
  end

endmodule

### tb/tb_top.sv
// ----------------------------------------------------------------------------
// tb_top
// Drives the envelope mask unit through a series of edge and window settings:
// a directed part with the extreme endpoints, coincident, horizontal and
// vertical edges and the largest windows, then random phases in which most
// pixels are aimed near the edge's normal band. The checker predicts and
// compares every result transfer.
// ----------------------------------------------------------------------------
module tb_top;

  logic               clk = 0;
  logic               rst = 1;
  logic               psel = 0, penable = 0, pwrite = 0;
  logic [4:0]         paddr = 0;
  logic [31:0]        pwdata = 0;
  logic [31:0]        prdata;
  logic               pready;
  logic               in_valid = 0;
  logic               in_stall;
  logic [15:0]        pixel_magnitude = 0;
  logic signed [14:0] pixel_angle = 0;
  logic               out_valid;
  logic               out_stall = 0;
  logic               inside_res, window_done;
  logic [9:0]         box_min_row, box_min_col, box_max_row, box_max_col;
  logic signed [14:0] tangent_angle;
  logic signed [10:0] top_x, top_y, bottom_x, bottom_y;
  int                 errors, pending;

  int  stall_pct = 0, gap_pct = 0, idle_cycles = 0;
  bit  hold_req = 0, hold_taken = 0;
  real edge_t, rho_a, rho_b;

  edge_normal_envelope_mask_unit uut (.*);

  enem_tb_checker checker_i (.*);

  always begin
    #1 clk = 1;
    #1 clk = 0;
  end

  // Receiver: random stalls, the odd long one, and one held-off stretch on request.
  always @(negedge clk) begin
    if (hold_req && !hold_taken) begin
      hold_taken = 1;
      out_stall = 1;
      repeat (400) @(negedge clk);
      out_stall = 0;
    end else if (stall_pct > 0 && $urandom_range(0, 199) == 0) begin
      out_stall = 1;
      repeat ($urandom_range(10, 40)) @(negedge clk);
      out_stall = 0;
    end else begin
      out_stall = ($urandom_range(0, 99) < stall_pct);
    end
  end

  always @(posedge clk) begin
    if (rst || (in_valid && !in_stall) || (out_valid && !out_stall) || psel)
      idle_cycles = 0;
    else
      idle_cycles++;
    if (idle_cycles >= 5000) begin
      $display("tb_top NOT OK");
      $finish;
    end
  end

  task automatic reg_write(logic [2:0] idx, logic [9:0] value);
    @(negedge clk);
    psel = 1; pwrite = 1; penable = 0;
    paddr = {idx, 2'b00};
    pwdata = {22'($urandom_range(0, 4194303)), value};
    @(negedge clk);
    penable = 1;
    do @(posedge clk); while (!pready);
    @(negedge clk);
    psel = 0; penable = 0; pwrite = 0;
  endtask

  task automatic drain();
    do @(posedge clk); while (pending != 0);
    repeat (40) @(posedge clk);
  endtask

  // Writes the edge and window, and keeps a rough real-valued copy of the
  // normal band so that random pixels can be aimed at it.
  task automatic set_edge(int r1, int c1, int r2, int c2, int lr, int lc);
    real x1, y1, x2, y2, tmp;
    drain();
    reg_write(enem_pkg::REG_FIRST_ROW, 10'(r1));
    reg_write(enem_pkg::REG_FIRST_COL, 10'(c1));
    reg_write(enem_pkg::REG_END_ROW, 10'(r2));
    reg_write(enem_pkg::REG_END_COL, 10'(c2));
    reg_write(enem_pkg::REG_WINDOW_LAST_ROW, 10'(lr));
    reg_write(enem_pkg::REG_WINDOW_LAST_COL, 10'(lc));
    x1 = c1 - 1; y1 = 1 - r1; x2 = c2 - 1; y2 = 1 - r2;
    if ((y1 != y2) ? (y1 < y2) : (x2 < x1)) begin
      tmp = x1; x1 = x2; x2 = tmp;
      tmp = y1; y1 = y2; y2 = tmp;
    end
    edge_t = (x1 == x2 && y1 == y2) ? 0.0 : $atan2(y2 - y1, x2 - x1);
    rho_a = x1 * $cos(edge_t) + y1 * $sin(edge_t);
    rho_b = x2 * $cos(edge_t) + y2 * $sin(edge_t);
  endtask

  task automatic send(logic [15:0] mag, logic signed [14:0] ang);
    @(negedge clk);
    in_valid = 1;
    pixel_magnitude = mag;
    pixel_angle = ang;
    do @(posedge clk); while (in_stall);
    if ($urandom_range(0, 99) < gap_pct) begin
      @(negedge clk);
      in_valid = 0;
      pixel_magnitude = 16'($urandom);
      pixel_angle = 15'($urandom);
      if ($urandom_range(0, 19) == 0) repeat ($urandom_range(10, 50)) @(negedge clk);
      else repeat ($urandom_range(0, 2)) @(negedge clk);
    end
  endtask

  task automatic send_random();
    real target, a;
    int  code, m;
    if ($urandom_range(0, 99) < 35) begin
      send(16'($urandom), 15'($urandom));
    end else begin
      target = rho_a + (rho_b - rho_a) * ($urandom_range(0, 1200) - 100) / 1000.0;
      a = edge_t;
      if (target < 0) begin
        target = -target;
        a = a + 3.14159265358979;
      end
      code = $rtoi(a * 4096.0) + $urandom_range(0, 8) - 4;
      if (code > 16383) code -= 25736;
      if (code < -16384) code += 25736;
      m = $rtoi(target * 16.0) + $urandom_range(0, 6) - 3;
      if (m < 0) m = 0;
      if (m > 65535) m = 65535;
      send(16'(m), 15'(code));
    end
  endtask

  task automatic run_phase(int n);
    repeat (n) send_random();
    @(negedge clk);
    in_valid = 0;
  endtask

  initial begin
    repeat (9) @(posedge clk);
    @(negedge clk);
    rst = 0;

    // Default registers: coincident endpoints, one-pixel window.
    edge_t = 0.0; rho_a = 0.0; rho_b = 0.0;
    send(16'h0000, 15'sh0000);
    send(16'hffff, 15'sh4000);
    send(16'h0000, 15'sh3fff);
    @(negedge clk);
    in_valid = 0;

    set_edge(1, 1, 1, 1, 1, 2);                // coincident
    run_phase(6);
    set_edge(500, 10, 500, 900, 2, 1);         // horizontal
    run_phase(6);
    set_edge(5, 300, 800, 300, 0, 3);          // vertical
    run_phase(4);
    set_edge(0, 0, 1023, 1023, 3, 3);
    send(16'hffff, 15'sh3fff);
    send(16'h0001, 15'sh4000);
    run_phase(3);
    set_edge(1023, 0, 0, 1023, 1023, 0);       // tall window, left unfinished
    stall_pct = 10; gap_pct = 10;
    run_phase(300);
    set_edge(0, 1023, 1023, 0, 0, 1023);       // wide window, left unfinished
    run_phase(150);
    set_edge(20, 40, 30, 10, 2, 2);            // shrunk while mid-window
    run_phase(30);

    // Receiver held off while pixels keep coming.
    stall_pct = 0; gap_pct = 0;
    hold_req = 1;
    run_phase(120);

    for (int p = 0; p < 24; p++) begin
      stall_pct = (p % 4 == 0) ? 0 : $urandom_range(0, 50);
      gap_pct   = (p % 4 == 1) ? 0 : $urandom_range(0, 50);
      if (p % 3 == 0)
        set_edge($urandom_range(0, 1023), $urandom_range(0, 1023),
                 $urandom_range(0, 1023), $urandom_range(0, 1023),
                 $urandom_range(0, 7), $urandom_range(0, 7));
      else
        set_edge($urandom_range(0, 40), $urandom_range(0, 40),
                 $urandom_range(0, 40), $urandom_range(0, 40),
                 $urandom_range(0, 5), $urandom_range(0, 9));
      run_phase(25);
    end

    drain();
    if (errors == 0) $display("tb_top OK");
    else $display("tb_top NOT OK");
    $finish;
  end

endmodule
